// ===== hw/rtl/tdp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

  // status of the bit-serial remainder unit, seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } rem_stat_t;

  // the two smallest primes the sequencer knows about
  localparam int unsigned FIRST_PRIME = 2;
  localparam int unsigned FIRST_ODD_DIVISOR = 3;

endpackage

`default_nettype wire

// ===== hw/rtl/tdp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tdp_in_if #(
  parameter int VALUE_BITS = 52
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tdp_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdp_rem #(
  parameter int VALUE_BITS = 52,
  parameter int DIV_BITS   = 28
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [VALUE_BITS-1:0]       value,
  input  wire [DIV_BITS-1:0]         divisor,
  output tdp_pkg::rem_stat_t         stat
);
  import tdp_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] shv_r, shv_nxt;
  logic [DIV_BITS-1:0]   rem_r, rem_nxt;
  logic [DIV_BITS-1:0]   div_r, div_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;

  // restoring division, one dividend bit per cycle, msb first
  assign trial = {rem_r, shv_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    shv_nxt  = shv_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      shv_nxt  = value;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = CW'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      shv_nxt = {shv_r[VALUE_BITS-2:0], 1'b0};
      // remainder stays below the divisor, so the top bit drops off
      rem_nxt = diff[DIV_BITS] ? trial[DIV_BITS-1:0] : diff[DIV_BITS-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shv_r <= shv_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign stat.busy     = busy_r;
  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("remainder done without a running division");

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("remainder unit busy and done together");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0)
    else $error("bit counter left running while idle");

endmodule

`default_nettype wire

// ===== hw/rtl/trial_division_primality_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  fields                      handshake
// in_chan   input      candidate[VALUE_BITS-1:0]   valid / ready
// out_chan  output     is_prime                    valid / ready
//
// each trial divisor goes through a bound check on the running square, then the
// bit-serial remainder unit, then a step on to the next odd divisor.
// a prime near 2^VALUE_BITS needs about 2^(VALUE_BITS/2-1) trials; values below
// 2 and even values skip the trials. reset is synchronous, active low, and clears
// the sequencer state and the output valid flag. a stalled result holds in the
// output register while the next request is taken and worked on.

module trial_division_primality_test #(
  parameter int VALUE_BITS = 52
) (
  input  wire        clk,
  input  wire        rst_n,
  tdp_in_if.sink     in_chan,
  tdp_out_if.source  out_chan
);
  import tdp_pkg::*;

  localparam int DW  = (VALUE_BITS + 1) / 2 + 2;
  localparam int SQW = VALUE_BITS + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [DW-1:0]         d_r, d_nxt;
  logic [SQW-1:0]        sq_r, sq_nxt;
  logic                  res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_prime_r, out_prime_nxt;
  logic                  div_start;
  logic                  in_acc;
  rem_stat_t             rstat;

  tdp_rem #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DW)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .value   (v_r),
    .divisor (d_r),
    .stat    (rstat)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          v_nxt  = in_chan.candidate;
          d_nxt  = DW'(FIRST_ODD_DIVISOR);
          sq_nxt = SQW'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
          if (in_chan.candidate < VALUE_BITS'(FIRST_PRIME)) begin
            res_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end else if (!in_chan.candidate[0]) begin
            res_nxt   = (in_chan.candidate == VALUE_BITS'(FIRST_PRIME));
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // stop once the divisor squared passes the value
        if (sq_r > {2'b00, v_r}) begin
          res_nxt   = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rstat.done) begin
          if (rstat.rem_zero) begin
            res_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            d_nxt     = d_r + DW'(2);
            sq_nxt    = sq_r + SQW'({d_r, 2'b00}) + SQW'(4);
            state_nxt = S_CHECK;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r         <= v_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.is_prime = out_prime_r;

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rstat.busy || rstat.done))
    else $error("waiting on a remainder that is not being computed");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rstat.done |-> (state_r == S_DIV))
    else $error("remainder finished outside the divide state");

  a_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> d_r[0])
    else $error("trial divisor is even");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result raised without a finished test");

endmodule

`default_nettype wire

// ===== verif/tb_trial_division_primality_test.sv =====
`timescale 1ns / 1ps

module tb_trial_division_primality_test;
  import tdp_pkg::*;

  localparam int VB = 52;
  localparam logic [VB-1:0] VAL_MAX = '1;
  localparam logic [VB-1:0] VAL_TOP = VAL_MAX ^ (VAL_MAX >> 1);

  class prime_scoreboard;
    logic [VB-1:0]   cand_q[$];
    bit              verdict_q[$];
    int              failures;
    longint unsigned cycle_budget;

    function new();
      failures = 0;
      cycle_budget = 0;
    endfunction

    // odd divisors from 3 while d <= v / d, counting the trials made
    function bit divides_out(input logic [VB-1:0] cand, output int unsigned trials);
      longint unsigned v;
      longint unsigned d;
      v = 64'(cand);
      trials = 0;
      if (v < FIRST_PRIME) return 1'b0;
      if (v % 2 == 0) return v == FIRST_PRIME;
      for (d = 64'(FIRST_ODD_DIVISOR); d <= v / d; d += 2) begin
        trials++;
        if (v % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(input logic [VB-1:0] cand);
      int unsigned trials;
      bit          verdict;
      verdict = divides_out(cand, trials);
      cand_q.push_back(cand);
      verdict_q.push_back(verdict);
      cycle_budget += longint'(trials + 4) * (VB + 2) + 100;
    endfunction

    function void check_result(input logic got);
      logic [VB-1:0] cand;
      bit            want;
      if (verdict_q.size() == 0) begin
        $error("is_prime: result with no request waiting, expected none, actual %0b", got);
        failures++;
        return;
      end
      cand = cand_q.pop_front();
      want = verdict_q.pop_front();
      if (got !== want) begin
        $error("is_prime (candidate %0d): expected %0b, actual %0b", cand, want, got);
        failures++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tdp_in_if #(.VALUE_BITS(VB)) in_chan ();
  tdp_out_if                   out_chan ();

  trial_division_primality_test #(.VALUE_BITS(VB)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  prime_scoreboard sb = new();

  int              tx_idle_pct = 16;
  int              rx_idle_pct = 16;
  int              rx_hold_cycles = 0;
  longint unsigned cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_chan.ready <= 1'b0;
      rx_hold_cycles--;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) sb.note_request(in_chan.candidate);
      if (out_chan.valid && out_chan.ready) sb.check_result(out_chan.is_prime);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 4 * sb.cycle_budget + 200000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_candidate(input logic [VB-1:0] cand);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.candidate <= cand;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  function automatic logic [VB-1:0] wide_random();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[VB-1:0];
  endfunction

  // primes stay below about 2^20 so a request never runs long; wide values
  // always carry a small factor
  function automatic logic [VB-1:0] pick_candidate();
    int            sel;
    int unsigned   k;
    logic [VB-1:0] w;
    sel = $urandom_range(99);
    if (sel < 45) return VB'($urandom_range(4095));
    if (sel < 60) return VB'($urandom_range(65535));
    if (sel < 65) return VB'($urandom_range(1 << 20));
    if (sel < 80) return wide_random() & ~VB'(1);
    k = $urandom_range(13, 3);
    w = wide_random();
    return (w / k) * k;
  endfunction

  initial begin
    logic [VB-1:0] directed_q[$];

    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.candidate = '0;
    out_chan.ready    = 1'b0;

    // zero and one, two, small primes, squares on the loop bound, widest values
    directed_q = '{0, 1, 2, 3, 4, 5, 7, 9, 15, 25, 49, 91, 97, 121, 65521, 65537,
                   1000003, 1018081, 1022117};
    directed_q.push_back(VAL_MAX);
    directed_q.push_back(VAL_MAX - 1);
    directed_q.push_back(VAL_TOP);
    directed_q.push_back(VAL_TOP + 1);

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (directed_q[i]) send_candidate(directed_q[i]);

    // back to back, no stalls on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (40) send_candidate(pick_candidate());

    // receiver holds off while requests keep coming, so the input backs up
    tx_idle_pct = 16;
    rx_idle_pct = 16;
    rx_hold_cycles = 3000;
    repeat (10) send_candidate(VB'($urandom_range(255)));

    @(negedge clk) in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    repeat (50) send_candidate(pick_candidate());

    @(negedge clk) in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * (VB + 2)) @(posedge clk);

    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tdp_pkg.sv
hw/rtl/tdp_if.sv
hw/rtl/tdp_rem.sv
hw/rtl/trial_division_primality_test.sv
verif/tb_trial_division_primality_test.sv
